FILE: rtl/core/fit_policy_word_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_WORD_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_WORD_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define FPWA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define FPWA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/fpwa_pkg.sv
// Shared constants and types of the fit-policy word allocator.
package fpwa_pkg;

	localparam int DEF_MAX_WORDS = 1024;

	localparam int STATUS_W  = 2;
	localparam int WOFF_W    = 10;
	localparam int BYTES_W   = 16;
	localparam int WB_W      = 4;
	localparam int MW_W      = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_BLOCK = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NO_INIT   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_BYTES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_WORDS = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic               start;
		logic [WB_W-1:0]    divisor;
		logic [BYTES_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [BYTES_W-1:0] quotient;
		logic [WB_W-1:0]    remainder;
	} div_rsp_t;

endpackage

FILE: rtl/core/fpwa_if.sv
// Request and response channel interfaces of the allocator.
interface fpwa_req_if import fpwa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [BYTES_W-1:0] request_bytes;
	logic [BYTES_W-1:0] free_byte_offset;

	modport source (output valid, opcode, request_bytes, free_byte_offset, input ready);
	modport sink (input valid, opcode, request_bytes, free_byte_offset, output ready);
endinterface

interface fpwa_rsp_if import fpwa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WOFF_W-1:0]   word_offset;
	logic [BYTES_W-1:0]  byte_offset;

	modport source (output valid, status, word_offset, byte_offset, input ready);
	modport sink (input valid, status, word_offset, byte_offset, output ready);
endinterface

FILE: rtl/core/fpwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/fpwa_div.sv
// Bit-serial restoring divider of a byte count by the word size.
module fpwa_div import fpwa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [BYTES_W-1:0] quo_q;
	logic [WB_W-1:0]    rem_q;
	logic [WB_W-1:0]    dvs_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [WB_W:0]      sh;
	logic               ge;

	assign sh = {rem_q, quo_q[BYTES_W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[BYTES_W-2:0], ge};
			rem_q <= ge ? WB_W'(sh - {1'b0, dvs_q}) : sh[WB_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
endmodule

FILE: rtl/core/fit_policy_word_allocator.sv
// Word allocator over a block table kept in one RAM, one entry per word offset. An allocate
// first turns bytes into words in the serial divider, then reads every entry of the pool in
// offset order through the single RAM read port; a free first turns the byte offset into a
// word offset in the same divider, then walks the table back to the preceding block start,
// which is short when blocks are large and up to the offset itself otherwise. After reset and
// after every write of memory_words all MAX_WORDS entries of the table are cleared, one entry per
// cycle, and no request is taken meanwhile. One request is worked on at a time; the next may
// be taken while the previous response waits in the output register.
module fit_policy_word_allocator import fpwa_pkg::*; #(
	parameter int MAX_WORDS = DEF_MAX_WORDS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [MW_W-1:0]      cfg_data,
	fpwa_req_if.sink             req,
	fpwa_rsp_if.source           rsp
);
	localparam int AW = $clog2(MAX_WORDS);
	localparam int CW = AW + 1;
	localparam int EW = CW + 2;
	localparam int WW = BYTES_W + 1;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_ASCAN = 4'd3;
	localparam logic [3:0] S_AWR1  = 4'd4;
	localparam logic [3:0] S_AWR2  = 4'd5;
	localparam logic [3:0] S_FRD0  = 4'd6;
	localparam logic [3:0] S_FRD1  = 4'd7;
	localparam logic [3:0] S_FNXT  = 4'd8;
	localparam logic [3:0] S_FPRV  = 4'd9;
	localparam logic [3:0] S_FWR1  = 4'd10;
	localparam logic [3:0] S_FWR2  = 4'd11;
	localparam logic [3:0] S_RES   = 4'd12;

	logic [3:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic                pol_q;
	logic [WB_W-1:0]     wb_q;
	logic [CW-1:0]       mw_q;
	logic                op_q;
	logic [WW-1:0]       words_q;
	logic                found_q;
	logic [AW-1:0]       ch_q;
	logic [CW-1:0]       ch_size_q;
	logic [AW-1:0]       off_q;
	logic [CW-1:0]       size_off_q;
	logic [AW-1:0]       p_q;
	logic                iss_done_q;
	logic                mrg_q;
	logic [AW-1:0]       prev_q;
	logic [CW-1:0]       prev_size_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;
	logic [STATUS_W-1:0] res_status_q;
	logic [AW-1:0]       res_woff_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [WOFF_W-1:0]   rsp_woff_q;
	logic [BYTES_W-1:0]  rsp_boff_q;

	logic [WB_W-1:0]     wb_eff;
	logic                req_xfer;
	logic [CW-1:0]       mw_sat;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [EW-1:0]       ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;
	logic                rd_start;
	logic                rd_hole;
	logic [CW-1:0]       rd_size;
	logic [CW-1:0]       next_w;
	logic [WW-1:0]       words_w;
	logic                fits;
	logic                better;
	logic [31:0]         prod;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign wb_eff   = (wb_q == '0) ? WB_W'(1) : wb_q;
	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	assign mw_sat = (32'(cfg_data) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(cfg_data);

	assign rd_start = ram_rdata[CW+1];
	assign rd_hole  = ram_rdata[CW];
	assign rd_size  = ram_rdata[CW-1:0];
	assign next_w   = CW'(off_q) + rd_size;
	assign words_w  = WW'(div_rsp.quotient) + WW'(div_rsp.remainder != '0);

	assign fits   = rd_start && rd_hole && (32'(rd_size) >= 32'(words_q));
	assign better = !found_q || (pol_q ? (rd_size > ch_size_q) : (rd_size < ch_size_q));

	assign prod = 32'(res_woff_q) * 32'(wb_eff);

	assign div_req.start    = req_xfer && (mw_q != '0);
	assign div_req.divisor  = wb_eff;
	assign div_req.dividend = (req.opcode == OP_FREE) ? req.free_byte_offset
		: req.request_bytes;

	fpwa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fpwa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_WORDS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = off_q;
		ram_wdata = '0;
		ram_raddr = off_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				if (cnt_q == '0 && mw_q != '0) begin
					ram_wdata = {1'b1, 1'b1, mw_q};
				end
			end
			S_ASCAN: begin
				ram_raddr = cnt_q[AW-1:0];
			end
			S_AWR1: begin
				ram_we    = 1'b1;
				ram_waddr = ch_q;
				ram_wdata = {1'b1, 1'b0,
					(32'(ch_size_q) > 32'(words_q)) ? CW'(words_q) : ch_size_q};
			end
			S_AWR2: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(CW'(ch_q) + CW'(words_q));
				ram_wdata = {1'b1, 1'b1, CW'(ch_size_q - CW'(words_q))};
			end
			S_FRD1: begin
				ram_raddr = next_w[AW-1:0];
			end
			S_FNXT: begin
				// The following hole is absorbed, so its entry stops being a block start.
				ram_we    = rd_start && rd_hole;
				ram_waddr = AW'(CW'(off_q) + size_off_q);
			end
			S_FPRV: begin
				ram_raddr = p_q;
			end
			S_FWR1: begin
				ram_we = 1'b1;
				if (mrg_q) begin
					ram_waddr = prev_q;
					ram_wdata = {1'b1, 1'b1, CW'(prev_size_q + size_off_q)};
				end else begin
					ram_waddr = off_q;
					ram_wdata = {1'b1, 1'b1, size_off_q};
				end
			end
			S_FWR2: begin
				ram_we    = 1'b1;
				ram_waddr = off_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			pol_q       <= 1'b0;
			wb_q        <= WB_W'(1);
			mw_q        <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			iss_done_q  <= 1'b0;
			mrg_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAX_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						op_q <= req.opcode;
						if (mw_q == '0) begin
							res_status_q <= STATUS_NO_INIT;
							res_woff_q   <= '0;
							state_q      <= S_RES;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_woff_q <= '0;
						if (op_q == OP_ALLOC) begin
							if (words_w == '0) begin
								res_status_q <= STATUS_NO_FIT;
								state_q      <= S_RES;
							end else begin
								words_q <= words_w;
								found_q <= 1'b0;
								cnt_q   <= '0;
								vld_s1  <= 1'b0;
								state_q <= S_ASCAN;
							end
						end else if (32'(div_rsp.quotient) >= 32'(mw_q)) begin
							res_status_q <= STATUS_NOT_BLOCK;
							state_q      <= S_RES;
						end else begin
							off_q   <= AW'(div_rsp.quotient);
							state_q <= S_FRD0;
						end
					end
				end
				S_ASCAN: begin
					if (cnt_q < mw_q) begin
						vld_s1  <= 1'b1;
						addr_s1 <= cnt_q[AW-1:0];
						cnt_q   <= cnt_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && fits && better) begin
						found_q   <= 1'b1;
						ch_q      <= addr_s1;
						ch_size_q <= rd_size;
					end
					if (cnt_q >= mw_q && !vld_s1) begin
						if (found_q) begin
							state_q <= S_AWR1;
						end else begin
							res_status_q <= STATUS_NO_FIT;
							state_q      <= S_RES;
						end
					end
				end
				S_AWR1: begin
					res_status_q <= STATUS_OK;
					res_woff_q   <= ch_q;
					state_q      <= (32'(ch_size_q) > 32'(words_q)) ? S_AWR2 : S_RES;
				end
				S_AWR2: begin
					state_q <= S_RES;
				end
				S_FRD0: begin
					state_q <= S_FRD1;
				end
				S_FRD1: begin
					if (!rd_start) begin
						res_status_q <= STATUS_NOT_BLOCK;
						state_q      <= S_RES;
					end else begin
						size_off_q <= rd_size;
						mrg_q      <= 1'b0;
						if (next_w < mw_q) begin
							state_q <= S_FNXT;
						end else if (off_q == '0) begin
							state_q <= S_FWR1;
						end else begin
							p_q        <= off_q - AW'(1);
							iss_done_q <= 1'b0;
							vld_s1     <= 1'b0;
							state_q    <= S_FPRV;
						end
					end
				end
				S_FNXT: begin
					if (rd_start && rd_hole) begin
						size_off_q <= size_off_q + rd_size;
					end
					if (off_q == '0) begin
						state_q <= S_FWR1;
					end else begin
						p_q        <= off_q - AW'(1);
						iss_done_q <= 1'b0;
						vld_s1     <= 1'b0;
						state_q    <= S_FPRV;
					end
				end
				S_FPRV: begin
					// Reads run ahead of the check; the first start seen going down wins.
					vld_s1  <= !iss_done_q;
					addr_s1 <= p_q;
					if (!iss_done_q) begin
						if (p_q == '0) begin
							iss_done_q <= 1'b1;
						end else begin
							p_q <= p_q - AW'(1);
						end
					end
					if (vld_s1 && rd_start) begin
						mrg_q       <= rd_hole;
						prev_q      <= addr_s1;
						prev_size_q <= rd_size;
						vld_s1      <= 1'b0;
						state_q     <= S_FWR1;
					end else if (vld_s1 && addr_s1 == '0) begin
						vld_s1  <= 1'b0;
						state_q <= S_FWR1;
					end
				end
				S_FWR1: begin
					res_status_q <= STATUS_OK;
					state_q      <= mrg_q ? S_FWR2 : S_RES;
				end
				S_FWR2: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_woff_q   <= WOFF_W'(res_woff_q);
						rsp_boff_q   <= prod[BYTES_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FIT_POLICY: begin
						pol_q <= cfg_data[0];
					end
					CFG_WORD_BYTES: begin
						wb_q <= cfg_data[WB_W-1:0];
					end
					CFG_MEMORY_WORDS: begin
						mw_q    <= mw_sat;
						cnt_q   <= '0;
						state_q <= S_CLR;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.word_offset = rsp_woff_q;
	assign rsp.byte_offset = rsp_boff_q;

`include "fit_policy_word_allocator_macros.svh"

	`FPWA_ASSERT_IMP(a_fail_zero, rsp.valid && rsp.status != STATUS_OK, rsp.word_offset == '0 && rsp.byte_offset == '0, "failed response carries an offset")
	`FPWA_ASSERT_IMP(a_scan_no_write, state_q == S_ASCAN || state_q == S_FPRV, !ram_we, "table written during a scan")
	`FPWA_ASSERT_NXT(a_take_leaves_idle, req_xfer && !cfg_we, state_q != S_IDLE, "accepted request left no work")
endmodule

FILE: verif/tb.sv
// Self-checking testbench of the fit-policy word allocator with a built-in block-table predictor.
module tb;
	import fpwa_pkg::*;

	localparam int  POOL_MAX    = DEF_MAX_WORDS;
	localparam int  CYCLE_LIMIT = 4000000;
	localparam int  TARGET      = 580;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WOFF_W-1:0]   word_offset;
		logic [BYTES_W-1:0]  byte_offset;
	} alloc_result_t;

	typedef enum logic {ROW_SETUP, ROW_ITEM} row_kind_e;

	typedef struct {
		row_kind_e          kind;
		logic               op;
		logic [BYTES_W-1:0] nbytes;
		logic [BYTES_W-1:0] ofs;
		bit                 typed;
		alloc_result_t      want;
		int                 fp, wb, mw;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [MW_W-1:0]      cfg_data;

	fpwa_req_if req_ch ();
	fpwa_rsp_if rsp_ch ();

	fit_policy_word_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
	);

	// Predictor state: configuration and the block table.
	bit         pol_worst;
	int         bytes_per_word;
	int         pool_words;
	bit         blk_start [POOL_MAX];
	int         blk_size  [POOL_MAX];
	bit         blk_hole  [POOL_MAX];

	alloc_result_t pending_results[$];
	int         live_blocks[$];
	int         errors;
	longint     cycles;
	stim_row_t  rows[$];
	int         items_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[fit_policy_word_allocator] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic int eff_bytes();
		return bytes_per_word == 0 ? 1 : bytes_per_word;
	endfunction

	function automatic void clear_pool();
		for (int i = 0; i < POOL_MAX; i++) begin
			blk_start[i] = 0;
			blk_size[i] = 0;
			blk_hole[i] = 0;
		end
		if (pool_words != 0) begin
			blk_start[0] = 1;
			blk_size[0] = pool_words;
			blk_hole[0] = 1;
		end
	endfunction

	function automatic alloc_result_t make_result(logic [STATUS_W-1:0] st, int woff);
		alloc_result_t r;
		r.status = st;
		r.word_offset = woff[WOFF_W-1:0];
		r.byte_offset = BYTES_W'(woff * eff_bytes());
		return r;
	endfunction

	function automatic alloc_result_t allocate_words(int nbytes);
		int wb, words, chosen, chosen_size, rest;
		bit found;
		wb = eff_bytes();
		words = (nbytes + wb - 1) / wb;
		found = 0;
		chosen = 0;
		chosen_size = 0;
		if (words == 0)
			return make_result(STATUS_NO_FIT, 0);
		for (int i = 0; i < pool_words; i++) begin
			if (blk_start[i] && blk_hole[i] && blk_size[i] >= words) begin
				if (!found || (pol_worst ? blk_size[i] > chosen_size
						: blk_size[i] < chosen_size)) begin
					found = 1;
					chosen = i;
					chosen_size = blk_size[i];
				end
			end
		end
		if (!found)
			return make_result(STATUS_NO_FIT, 0);
		blk_hole[chosen] = 0;
		if (chosen_size > words) begin
			rest = chosen + words;
			blk_size[chosen] = words;
			if (rest < POOL_MAX) begin
				blk_start[rest] = 1;
				blk_size[rest] = chosen_size - words;
				blk_hole[rest] = 1;
			end
		end
		return make_result(STATUS_OK, chosen);
	endfunction

	function automatic alloc_result_t free_block(int byte_ofs);
		int off, nxt, p;
		bit have_prev;
		off = byte_ofs / eff_bytes();
		if (off >= pool_words || !blk_start[off])
			return make_result(STATUS_NOT_BLOCK, 0);
		blk_hole[off] = 1;
		nxt = off + blk_size[off];
		if (nxt < pool_words && blk_start[nxt] && blk_hole[nxt]) begin
			blk_size[off] += blk_size[nxt];
			blk_start[nxt] = 0;
			blk_hole[nxt] = 0;
			blk_size[nxt] = 0;
		end
		// Walk back to the preceding block start; offset zero has none.
		if (off > 0) begin
			p = off;
			have_prev = 0;
			while (p > 0) begin
				p--;
				if (blk_start[p]) begin
					have_prev = 1;
					break;
				end
			end
			if (have_prev && blk_hole[p]) begin
				blk_size[p] += blk_size[off];
				blk_start[off] = 0;
				blk_hole[off] = 0;
				blk_size[off] = 0;
			end
		end
		return make_result(STATUS_OK, 0);
	endfunction

	function automatic alloc_result_t predict(logic op, int nbytes, int ofs);
		if (pool_words == 0)
			return make_result(STATUS_NO_INIT, 0);
		return op == OP_ALLOC ? allocate_words(nbytes) : free_block(ofs);
	endfunction

	// The request is withdrawn first, so an accepted item is never offered a second time.
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		req_ch.valid = 1'b0;
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = MW_W'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_FIT_POLICY) begin
			pol_worst = val[0];
		end else if (idx == CFG_WORD_BYTES) begin
			bytes_per_word = val & 15;
		end else begin
			pool_words = (val & 11'h7FF) > POOL_MAX ? POOL_MAX : (val & 11'h7FF);
			clear_pool();
			live_blocks.delete();
		end
	endtask

	task automatic setup_pool(input int fp, input int wb, input int mw);
		wait_drained();
		write_reg(CFG_FIT_POLICY, fp);
		write_reg(CFG_WORD_BYTES, wb);
		if (mw >= 0)
			write_reg(CFG_MEMORY_WORDS, mw);
	endtask

	task automatic send_item(input logic op, input int nbytes, input int ofs,
			input bit typed, input alloc_result_t want, output alloc_result_t got);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.request_bytes = BYTES_W'(nbytes);
		req_ch.free_byte_offset = BYTES_W'(ofs);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		got = predict(op, nbytes, ofs);
		pending_results.push_back(typed ? want : got);
		items_sent++;
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		req_ch.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic stim_row_t row_setup(int fp, int wb, int mw);
		stim_row_t r;
		r = '{kind: ROW_SETUP, default: 0};
		r.fp = fp;
		r.wb = wb;
		r.mw = mw;
		return r;
	endfunction

	function automatic stim_row_t row_item(logic op, int nb, int ofs);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: 0};
		r.op = op;
		r.nbytes = BYTES_W'(nb);
		r.ofs = BYTES_W'(ofs);
		return r;
	endfunction

	function automatic stim_row_t row_typed(logic op, int nb, int ofs,
			logic [STATUS_W-1:0] st, int wo, int bo);
		stim_row_t r;
		r = row_item(op, nb, ofs);
		r.typed = 1;
		r.want.status = st;
		r.want.word_offset = WOFF_W'(wo);
		r.want.byte_offset = BYTES_W'(bo);
		return r;
	endfunction

	// Response checker: every transfer on the response side must match the oldest prediction.
	always @(posedge clk) begin
		alloc_result_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response, status", rsp_ch.status, -1);
			end else begin
				w = pending_results.pop_front();
				if (rsp_ch.status !== w.status)
					report_mismatch("status", rsp_ch.status, w.status);
				if (rsp_ch.word_offset !== w.word_offset)
					report_mismatch("word_offset", rsp_ch.word_offset, w.word_offset);
				if (rsp_ch.byte_offset !== w.byte_offset)
					report_mismatch("byte_offset", rsp_ch.byte_offset, w.byte_offset);
			end
		end
	end

	// Response-side back-pressure: random stretches of stalls, flow, and long open periods.
	int stall_left;
	bit stall_val;
	initial begin
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		stall_val = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						stall_val = 1'b0;
						stall_left = $urandom_range(1, 25);
					end
					1: begin
						stall_val = 1'b1;
						stall_left = $urandom_range(50, 3000);
					end
					default: begin
						stall_val = $urandom_range(0, 1);
						stall_left = $urandom_range(1, 4);
					end
				endcase
			end
			stall_left--;
			rsp_ch.ready = stall_val;
		end
	end

	initial begin
		alloc_result_t got, none;
		int wb, mw, burst, op_pick, idx, phase_items;
		bit quiet;
		errors = 0;
		cycles = 0;
		items_sent = 0;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_FIT_POLICY;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ALLOC;
		req_ch.request_bytes = '0;
		req_ch.free_byte_offset = '0;
		pol_worst = 0;
		bytes_per_word = 1;
		pool_words = 0;
		clear_pool();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: uninitialized pool, boundary sizes, unaligned and stray frees,
		// frees at offset zero and of holes, both policies, saturated pool, zero word size.
		rows.push_back(row_typed(OP_ALLOC, 4, 0, STATUS_NO_INIT, 0, 0));
		rows.push_back(row_typed(OP_FREE, 0, 0, STATUS_NO_INIT, 0, 0));
		rows.push_back(row_setup(0, 4, 16));
		rows.push_back(row_typed(OP_ALLOC, 0, 0, STATUS_NO_FIT, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 65535, 0, STATUS_NO_FIT, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 5, 0, STATUS_OK, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 8, 0, STATUS_OK, 2, 8));
		rows.push_back(row_typed(OP_ALLOC, 1, 0, STATUS_OK, 4, 16));
		rows.push_back(row_item(OP_FREE, 0, 9));
		rows.push_back(row_typed(OP_FREE, 0, 4, STATUS_NOT_BLOCK, 0, 0));
		rows.push_back(row_typed(OP_FREE, 0, 65535, STATUS_NOT_BLOCK, 0, 0));
		rows.push_back(row_item(OP_ALLOC, 4, 0));
		rows.push_back(row_item(OP_FREE, 0, 0));
		rows.push_back(row_item(OP_FREE, 0, 0));
		rows.push_back(row_setup(1, 0, 2047));
		rows.push_back(row_typed(OP_ALLOC, 1, 0, STATUS_OK, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 1024, 0, STATUS_NO_FIT, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 1023, 0, STATUS_OK, 1, 1));
		rows.push_back(row_item(OP_FREE, 0, 0));
		rows.push_back(row_item(OP_ALLOC, 1, 0));
		rows.push_back(row_setup(0, 15, 1024));
		rows.push_back(row_typed(OP_ALLOC, 15345, 0, STATUS_OK, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 30, 0, STATUS_NO_FIT, 0, 0));
		rows.push_back(row_typed(OP_ALLOC, 15, 0, STATUS_OK, 1023, 15345));
		rows.push_back(row_item(OP_FREE, 0, 15345));
		rows.push_back(row_item(OP_FREE, 0, 0));
		rows.push_back(row_setup(1, 8, 0));
		rows.push_back(row_typed(OP_ALLOC, 1, 0, STATUS_NO_INIT, 0, 0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_SETUP)
				setup_pool(rows[i].fp, rows[i].wb, rows[i].mw);
			else
				send_item(rows[i].op, rows[i].nbytes, rows[i].ofs, rows[i].typed,
					rows[i].want, got);
		end

		// Random part: phases of random configuration, each a mix of fitting allocations,
		// frees of live blocks and a share of malformed requests.
		while (items_sent < TARGET) begin
			case ($urandom_range(0, 9))
				0: mw = POOL_MAX;
				1: mw = $urandom_range(1, 7);
				2: mw = $urandom_range(1025, 2047);
				3: mw = ($urandom_range(0, 5) == 0) ? 0 : -1;
				default: mw = $urandom_range(8, 64);
			endcase
			wb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			setup_pool($urandom_range(0, 1), wb, mw);
			phase_items = pool_words >= 256 ? $urandom_range(6, 14) : $urandom_range(30, 60);
			quiet = $urandom_range(0, 3) == 0;
			burst = $urandom_range(1, 30);
			for (int k = 0; k < phase_items; k++) begin
				if (k == phase_items / 2 && $urandom_range(0, 2) == 0) begin
					wait_drained();
					pause_sender(1);
				end
				if (!quiet && burst == 0) begin
					pause_sender($urandom_range(1, 8));
					burst = $urandom_range(1, 30);
				end
				if (burst > 0)
					burst--;
				op_pick = $urandom_range(0, 99);
				if (op_pick < 5) begin
					send_item(OP_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65535),
						0, none, got);
				end else if (op_pick < 9) begin
					send_item(OP_ALLOC, 0, $urandom_range(0, 65535), 0, none, got);
				end else if (op_pick < 14) begin
					send_item(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535),
						0, none, got);
				end else if (op_pick < 55 || live_blocks.size() == 0) begin
					send_item(OP_ALLOC,
						$urandom_range(1, (pool_words > 0 ? pool_words : 8) * eff_bytes() / 3 + 1),
						$urandom_range(0, 65535), 0, none, got);
					if (got.status == STATUS_OK)
						live_blocks.push_back(got.word_offset);
				end else begin
					idx = $urandom_range(0, live_blocks.size() - 1);
					send_item(OP_FREE, $urandom_range(0, 65535),
						live_blocks[idx] * eff_bytes() + $urandom_range(0, eff_bytes() - 1),
						0, none, got);
					live_blocks.delete(idx);
				end
			end
		end

		pause_sender(1);
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[fit_policy_word_allocator] OK");
		else
			$display("[fit_policy_word_allocator] ERROR");
		$finish;
	end

endmodule
